@@ src/oo_pkg.sv @@
`default_nettype none
package oo_pkg;

    localparam int SET_IDX_W     = 6;
    localparam int LINE_ADDR_W   = 64;
    localparam int WAYS_W        = 5;
    localparam int NSETS_W       = 7;
    localparam int TIME_W        = 32;
    localparam int SLOTS_PER_WAY = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;

    localparam logic [WAYS_W-1:0]  WAYS_RESET  = 5'd16;
    localparam logic [NSETS_W-1:0] NSETS_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAYS     = 1'b0,
        REG_NUM_SETS = 1'b1
    } cfg_reg_t;

endpackage
`default_nettype wire

@@ src/oo_if.sv @@
`default_nettype none
interface oo_in_if import oo_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SET_IDX_W-1:0]   set_index;
    logic [LINE_ADDR_W-1:0] line_address;
    modport source (output valid, output set_index, output line_address, input ready);
    modport sink   (input valid, input set_index, input line_address, output ready);
endinterface

interface oo_out_if;
    logic valid;
    logic ready;
    logic opt_hit;
    logic bad_set;
    modport source (output valid, output opt_hit, output bad_set, input ready);
    modport sink   (input valid, input opt_hit, input bad_set, output ready);
endinterface

interface oo_cfg_if import oo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/optgen_occupancy_oracle_unit.sv @@
`default_nettype none
// Belady OPT oracle for one cache, one query per access.
// in_ch carries set_index and line_address; out_ch returns opt_hit and bad_set,
// one result per accepted access, in order. cfg_ch writes ways (index 0) and
// num_sets_in_use (index 1); the user must write them only while no access is
// in flight, since the block itself does not enforce it. A rejected set is
// answered from the idle state; otherwise an access reads the set state,
// searches up to SEEN_ENTRIES last-seen entries and, on a match, checks the
// occupancy slots of the reuse window (at most the window length) and
// increments them if all have room. All set state sits in three
// single-port-pair memories, one entry read per cycle.
// One access is in work at a time; in_ch.ready is low while one is in work and
// while a result waits in the output register that out_ch.ready has not taken.
// A stalled receiver holds the result and thereby the next transfer on in_ch.
// After reset the per-set time, fill and table count are cleared, one set per
// cycle, through all SET_COUNT sets; in_ch is not ready meanwhile, cfg_ch always is.
// Reset sets ways to 16 and num_sets_in_use to 64.
module optgen_occupancy_oracle_unit
    import oo_pkg::*;
#(
    parameter int SET_COUNT    = 64,
    parameter int MAX_WAYS     = 16,
    parameter int WINDOW_DEPTH = 128,
    parameter int SEEN_ENTRIES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    oo_in_if.sink     in_ch,
    oo_out_if.source  out_ch,
    oo_cfg_if.sink    cfg_ch
);
    localparam int SW   = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
    localparam int EW   = SEEN_ENTRIES > 1 ? $clog2(SEEN_ENTRIES) : 1;
    localparam int CW   = $clog2(SEEN_ENTRIES + 1);
    localparam int SLW  = $clog2(WINDOW_DEPTH);
    localparam int FW   = $clog2(WINDOW_DEPTH + 1);
    localparam int OW   = $clog2(MAX_WAYS + 1);
    localparam int LW   = $clog2(SLOTS_PER_WAY * MAX_WAYS + 1);
    localparam int SEEN_DEPTH = SET_COUNT * SEEN_ENTRIES;
    localparam int OCC_DEPTH  = SET_COUNT * WINDOW_DEPTH;
    localparam int SAW  = SEEN_DEPTH > 1 ? $clog2(SEEN_DEPTH) : 1;
    localparam int OAW  = OCC_DEPTH > 1 ? $clog2(OCC_DEPTH) : 1;
    localparam int SEEN_W = LINE_ADDR_W + TIME_W;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [SLW-1:0]    slot;
        logic [FW-1:0]     fill;
        logic [CW-1:0]     cnt;
    } set_state_t;

    localparam int ST_W = $bits(set_state_t);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SETRD  = 9'b000000100,
        S_SEARCH = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_FOUND  = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_INC    = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [WAYS_W-1:0]      ways_reg;
    logic [NSETS_W-1:0]     nsets_reg;
    logic [SW-1:0]          clr_reg;
    logic [SW-1:0]          set_reg;
    logic [LINE_ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [SLW-1:0]         slot_reg;
    logic [FW-1:0]          fill_reg;
    logic [CW-1:0]          cnt_reg;
    logic [EW-1:0]          idx_reg;
    logic [EW-1:0]          victim_reg;
    logic [TIME_W-1:0]      best_age_reg;
    logic [TIME_W-1:0]      prev_reg;
    logic [EW-1:0]          found_reg;
    logic [SLW-1:0]         k_reg;
    logic [FW-1:0]          remain_reg;
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic                   bad_reg;

    // memory ports
    logic             st_we, st_re;
    logic [SW-1:0]    st_waddr, st_raddr;
    set_state_t       st_wdata;
    logic [ST_W-1:0]  st_rdata;
    logic             sn_we, sn_re;
    logic [SAW-1:0]   sn_waddr, sn_raddr;
    logic [SEEN_W-1:0] sn_wdata, sn_rdata;
    logic             oc_we, oc_re;
    logic [OAW-1:0]   oc_waddr, oc_raddr;
    logic [OW-1:0]    oc_wdata, oc_rdata;

    oo_ram #(.WIDTH(ST_W), .DEPTH(SET_COUNT)) u_set_ram (
        .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
    );
    oo_ram #(.WIDTH(SEEN_W), .DEPTH(SEEN_DEPTH)) u_seen_ram (
        .clk, .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .re(sn_re), .raddr(sn_raddr), .rdata(sn_rdata)
    );
    oo_ram #(.WIDTH(OW), .DEPTH(OCC_DEPTH)) u_occ_ram (
        .clk, .we(oc_we), .waddr(oc_waddr), .wdata(oc_wdata),
        .re(oc_re), .raddr(oc_raddr), .rdata(oc_rdata)
    );

    // derived values
    logic [OW-1:0]          eff_w;
    logic [LW-1:0]          wlen_raw;
    logic [FW-1:0]          wlen;
    logic                   in_fire, bad_in;
    set_state_t             st_rd;
    logic [LINE_ADDR_W-1:0] sn_addr_rd;
    logic [TIME_W-1:0]      sn_time_rd;
    logic [TIME_W-1:0]      age;
    logic [TIME_W-1:0]      gap;
    logic                   gap_ok;
    logic [SLW:0]           prev_wide;
    logic [SLW-1:0]         prev_slot;
    logic [SLW-1:0]         k_step;
    logic [SLW-1:0]         slot_step;
    logic [FW:0]            fill_inc;
    logic                   last_entry;
    logic                   table_full;

    assign eff_w    = (32'(ways_reg) > MAX_WAYS) ? OW'(MAX_WAYS) : OW'(ways_reg);
    assign wlen_raw = LW'(eff_w) * LW'(SLOTS_PER_WAY);
    assign wlen     = (32'(wlen_raw) > WINDOW_DEPTH) ? FW'(WINDOW_DEPTH) : FW'(wlen_raw);

    assign in_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign bad_in      = ({1'b0, in_ch.set_index} >= nsets_reg)
                      || (32'(in_ch.set_index) >= SET_COUNT);

    assign st_rd      = set_state_t'(st_rdata);
    assign sn_addr_rd = sn_rdata[SEEN_W-1:TIME_W];
    assign sn_time_rd = sn_rdata[TIME_W-1:0];
    assign age        = now_reg - sn_time_rd;
    assign gap        = now_reg - prev_reg;
    assign gap_ok     = (gap != '0) && (gap <= TIME_W'(fill_reg));
    assign prev_wide  = (TIME_W'(slot_reg) >= gap)
                      ? ((SLW+1)'(slot_reg) - (SLW+1)'(gap))
                      : ((SLW+1)'(slot_reg) + (SLW+1)'(WINDOW_DEPTH) - (SLW+1)'(gap));
    assign prev_slot  = prev_wide[SLW-1:0];
    assign k_step     = (32'(k_reg) == WINDOW_DEPTH - 1) ? '0 : k_reg + 1'b1;
    assign slot_step  = (32'(slot_reg) == WINDOW_DEPTH - 1) ? '0 : slot_reg + 1'b1;
    assign fill_inc   = (FW+1)'(fill_reg) + 1'b1;
    assign last_entry = (CW'(idx_reg) + 1'b1) == cnt_reg;
    assign table_full = 32'(cnt_reg) == SEEN_ENTRIES;

    assign cfg_ch.ready   = 1'b1;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.opt_hit = hit_reg;
    assign out_ch.bad_set = bad_reg;

    always_comb
    begin
        state_next = state_reg;
        st_we      = 1'b0;
        st_waddr   = set_reg;
        st_wdata   = '{now: now_reg + 1'b1, slot: slot_step,
                       fill: (fill_inc > (FW+1)'(wlen)) ? wlen : fill_inc[FW-1:0],
                       cnt: cnt_reg};
        st_re      = 1'b0;
        st_raddr   = SW'(in_ch.set_index);
        sn_we      = 1'b0;
        sn_waddr   = SAW'(SAW'(set_reg) * SAW'(SEEN_ENTRIES) + SAW'(found_reg));
        sn_wdata   = {addr_reg, now_reg};
        sn_re      = 1'b0;
        sn_raddr   = SAW'(SAW'(set_reg) * SAW'(SEEN_ENTRIES));
        oc_we      = 1'b0;
        oc_waddr   = OAW'(OAW'(set_reg) * OAW'(WINDOW_DEPTH) + OAW'(k_reg));
        oc_wdata   = oc_rdata + 1'b1;
        oc_re      = 1'b0;
        oc_raddr   = OAW'(OAW'(set_reg) * OAW'(WINDOW_DEPTH) + OAW'(k_step));
        unique case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                if (32'(clr_reg) == SET_COUNT - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire && !bad_in)
                begin
                    st_re      = 1'b1;
                    state_next = S_SETRD;
                end
            end
            S_SETRD:
            begin
                if (st_rd.cnt == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    sn_re      = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sn_addr_rd == addr_reg)
                begin
                    state_next = S_FOUND;
                end
                else if (last_entry)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    sn_re    = 1'b1;
                    sn_raddr = SAW'(SAW'(set_reg) * SAW'(SEEN_ENTRIES) + SAW'(idx_reg)
                                    + SAW'(1));
                end
            end
            S_DECIDE:
            begin
                sn_we    = 1'b1;
                sn_waddr = SAW'(SAW'(set_reg) * SAW'(SEEN_ENTRIES)
                                + (table_full ? SAW'(victim_reg) : SAW'(cnt_reg)));
                state_next = S_FINISH;
            end
            S_FOUND:
            begin
                sn_we = 1'b1;
                if (gap_ok)
                begin
                    oc_re      = 1'b1;
                    oc_raddr   = OAW'(OAW'(set_reg) * OAW'(WINDOW_DEPTH) + OAW'(prev_slot));
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                if (oc_rdata >= eff_w)
                begin
                    state_next = S_FINISH;
                end
                else if (remain_reg == FW'(1))
                begin
                    oc_re      = 1'b1;
                    oc_raddr   = OAW'(OAW'(set_reg) * OAW'(WINDOW_DEPTH) + OAW'(prev_slot));
                    state_next = S_INC;
                end
                else
                begin
                    oc_re = 1'b1;
                end
            end
            S_INC:
            begin
                oc_we = 1'b1;
                if (remain_reg == FW'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    oc_re = 1'b1;
                end
            end
            S_FINISH:
            begin
                st_we      = 1'b1;
                oc_we      = 1'b1;
                oc_waddr   = OAW'(OAW'(set_reg) * OAW'(WINDOW_DEPTH) + OAW'(slot_reg));
                oc_wdata   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            ways_reg      <= WAYS_RESET;
            nsets_reg     <= NSETS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                unique case (cfg_reg_t'(cfg_ch.index))
                    REG_WAYS:     ways_reg  <= cfg_ch.data[WAYS_W-1:0];
                    REG_NUM_SETS: nsets_reg <= cfg_ch.data[NSETS_W-1:0];
                    default:      ;
                endcase
            end
            if (in_fire && bad_in)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == S_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    set_reg  <= SW'(in_ch.set_index);
                    addr_reg <= in_ch.line_address;
                    hit_reg  <= 1'b0;
                    bad_reg  <= bad_in;
                end
            end
            S_SETRD:
            begin
                now_reg  <= st_rd.now;
                slot_reg <= st_rd.slot;
                fill_reg <= st_rd.fill;
                cnt_reg  <= st_rd.cnt;
                idx_reg  <= '0;
            end
            S_SEARCH:
            begin
                if (sn_addr_rd == addr_reg)
                begin
                    found_reg <= idx_reg;
                    prev_reg  <= sn_time_rd;
                end
                else
                begin
                    // keep the oldest entry, the lowest index on a tie
                    if (idx_reg == '0 || age > best_age_reg)
                    begin
                        best_age_reg <= age;
                        victim_reg   <= idx_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (!table_full)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            S_FOUND:
            begin
                k_reg      <= prev_slot;
                remain_reg <= gap[FW-1:0];
            end
            S_CHECK:
            begin
                if (remain_reg == FW'(1))
                begin
                    k_reg      <= prev_slot;
                    remain_reg <= gap[FW-1:0];
                end
                else
                begin
                    k_reg      <= k_step;
                    remain_reg <= remain_reg - 1'b1;
                end
            end
            S_INC:
            begin
                k_reg      <= k_step;
                remain_reg <= remain_reg - 1'b1;
                if (remain_reg == FW'(1))
                begin
                    hit_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // the increment walk meets the slot being opened for now only when the
    // reuse spans the whole ring, and then only at its first step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INC && 32'(remain_reg) < WINDOW_DEPTH) |-> (k_reg != slot_reg))
        else $error("increment walk reached the current slot");

    // a finished access never overwrites an undelivered result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !out_valid_reg)
        else $error("result register still full at finish");

    // the search stays within the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (CW'(idx_reg) < cnt_reg))
        else $error("search beyond filled entries");

    // a rejected set gives its result in the next cycle without touching state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && bad_in) |=> (out_valid_reg && bad_reg && state_reg == S_IDLE))
        else $error("rejected set not reported at once");
endmodule
`default_nettype wire

@@ src/oo_ram.sv @@
`default_nettype none
module oo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
